// ===== hdl/khte_pkg.sv =====
// khte_pkg: shared types, codes and hash helpers for the keyword hash table engine
// used by the datapath, the controller and the top; depends on nothing

package khte_pkg;

	localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME   = 32'd16777619;
	localparam logic [7:0]  CASE_OFFSET = 8'd32;
	localparam logic [7:0]  UPPER_A     = 8'd65;
	localparam logic [7:0]  UPPER_Z     = 8'd90;

	typedef logic [1:0] cmd_code_t;
	localparam cmd_code_t CMD_LOOKUP = 2'd0;
	localparam cmd_code_t CMD_ADD    = 2'd1;
	localparam cmd_code_t CMD_REMOVE = 2'd2;

	typedef logic [2:0] st_code_t;
	localparam st_code_t ST_OK   = 3'd0;
	localparam st_code_t ST_MISS = 3'd1;
	localparam st_code_t ST_DUP  = 3'd2;
	localparam st_code_t ST_FULL = 3'd3;
	localparam st_code_t ST_LONG = 3'd4;
	localparam st_code_t ST_NONE = 3'd5;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= UPPER_A && c <= UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
		logic [31:0] x;
		x = h ^ {24'd0, fold_case(c)};
		return x * FNV_PRIME;
	endfunction

	// commands from the controller to the datapath
	typedef struct packed {
		logic      take_item;
		logic      mod_start;
		logic      cur_head;
		logic      cur_next;
		logic      cur_inc;
		logic      cur_zero;
		logic      dst_zero;
		logic      dst_inc;
		logic      add_init;
		logic      bi_clr;
		logic      byte_go;
		logic      len_meta;
		logic      byte_hash;
		logic      byte_cmp;
		logic      byte_wr;
		logic      wr_from_key;
		logic      hash_init;
		logic      meta_wr_new;
		logic      meta_wr_copy;
		logic      link;
		logic      head_clr;
		logic      cnt_inc;
		logic      cnt_from_dst;
		logic      ver_inc;
		logic      res_set;
		logic      res_hit;
		st_code_t  res_status;
		logic      out_load;
	} dp_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		cmd_code_t cmd;
		logic      too_long;
		logic      mod_done;
		logic      walk_end;
		logic      len_eq;
		logic      mismatch;
		logic      byte_busy;
		logic      ext_eq;
		logic      cur_eq_dst;
		logic      cur_end;
		logic      dst_end;
		logic      full;
		logic      clr_last;
		logic      out_free;
	} dp_sts_t;

endpackage

// ===== hdl/khte_bmod.sv =====
// khte_bmod: reduces a 32-bit hash to a bucket index (hash mod BUCKETS)
// mask for power-of-two bucket counts, one byte per cycle reciprocal reduction otherwise

module khte_bmod #(
	parameter int BUCKETS = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                val,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] bkt
);

	localparam int BKT_W = $clog2(BUCKETS);
	localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

	generate
		if (POW2) begin : g_mask
			logic             done_q;
			logic [BKT_W-1:0] res_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else if (start) begin
					done_q <= 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					res_q <= val[BKT_W-1:0];
				end
			end

			assign done = done_q;
			assign bkt  = res_q;
		end else begin : g_div
			// rem = (rem * 256 + next byte) mod BUCKETS, quotient estimated by a
			// reciprocal multiply that is low by at most one, then one subtract
			localparam int TW = BKT_W + 8;
			localparam int PW = TW + 32;
			localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));
			localparam logic [TW-1:0] BK    = TW'(BUCKETS);
			logic             busy_q;
			logic             done_q;
			logic [31:0]      val_q;
			logic [BKT_W-1:0] rem_q;
			logic [1:0]       cnt_q;
			logic [TW-1:0]    t;
			logic [PW-1:0]    prod;
			logic [TW-1:0]    quo;
			logic [TW-1:0]    qb;
			logic [TW-1:0]    r_est;
			logic [TW-1:0]    r_sub;
			logic [BKT_W-1:0] rem_nxt;

			always_comb begin
				t       = {rem_q, val_q[31:24]};
				prod    = PW'(t) * PW'(RECIP);
				quo     = prod[PW-1:32];
				qb      = quo * BK;
				r_est   = t - qb;
				r_sub   = r_est - BK;
				rem_nxt = (r_est >= BK) ? r_sub[BKT_W-1:0] : r_est[BKT_W-1:0];
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
				end else if (start) begin
					busy_q <= 1'b1;
					done_q <= 1'b0;
				end else if (busy_q && cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					val_q <= val;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (busy_q) begin
					val_q <= {val_q[23:0], 8'd0};
					rem_q <= rem_nxt;
					cnt_q <= cnt_q + 2'd1;
				end
			end

			assign done = done_q;
			assign bkt  = rem_q;
		end
	endgenerate

endmodule

// ===== hdl/khte_dpath.sv =====
// khte_dpath: key capture, running hash, entry and bucket memories, result registers
// depends on khte_pkg and khte_bmod; driven by khte_ctrl through dp_cmd_t

module khte_dpath #(
	parameter int MAX_ENTRIES = 64,
	parameter int BUCKETS     = 128,
	parameter int MAX_KEY_LEN = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  khte_pkg::dp_cmd_t cmd,
	output khte_pkg::dp_sts_t sts,
	input  logic [1:0]        command,
	input  logic [7:0]        key_byte,
	input  logic              has_byte,
	input  logic [15:0]       code_in,
	input  logic [7:0]        extension_in,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [2:0]        status,
	output logic [15:0]       code_out,
	output logic [31:0]       version_out
);

	localparam int ENT_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int LEN_W  = $clog2(MAX_KEY_LEN + 2);
	localparam int KB_W   = $clog2(MAX_KEY_LEN);
	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int KMEM_D = MAX_ENTRIES * (2 ** KB_W);
	localparam logic [CNT_W-1:0] NO_ENTRY = CNT_W'(MAX_ENTRIES);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_KEY_LEN);
	localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

	// running key state
	logic [31:0]         hash_q;
	logic [LEN_W-1:0]    rlen_q;
	khte_pkg::cmd_code_t cmd_q;
	logic [15:0]         code_q;
	logic [7:0]          ext_q;

	// walk and sweep state
	logic [CNT_W-1:0]    cur_q;
	logic [CNT_W-1:0]    dst_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [31:0]         ver_q;
	logic [LEN_W-1:0]    bi_q;
	logic [LEN_W-1:0]    bi_s1;
	logic                vld_s1;
	logic                mis_q;
	logic [BKT_W-1:0]    clr_q;

	// result staging and output register
	khte_pkg::st_code_t  res_st_q;
	logic [15:0]         res_code_q;
	logic                out_valid_q;
	khte_pkg::st_code_t  out_st_q;
	logic [15:0]         out_code_q;
	logic [31:0]         out_ver_q;

	// memories
	logic [7:0]          key_mem  [0:KMEM_D-1];
	logic [7:0]          cap_mem  [0:MAX_KEY_LEN-1];
	logic [LEN_W-1:0]    len_mem  [0:MAX_ENTRIES-1];
	logic [15:0]         code_mem [0:MAX_ENTRIES-1];
	logic [7:0]          ext_mem  [0:MAX_ENTRIES-1];
	logic [CNT_W-1:0]    next_mem [0:MAX_ENTRIES-1];
	logic [CNT_W-1:0]    head_mem [0:BUCKETS-1];

	logic [7:0]          key_rd;
	logic [7:0]          cap_rd;
	logic [LEN_W-1:0]    len_rd;
	logic [15:0]         code_rd;
	logic [7:0]          ext_rd;
	logic [CNT_W-1:0]    next_rd;
	logic [CNT_W-1:0]    head_rd;

	logic                mod_done;
	logic [BKT_W-1:0]    bkt;
	logic [LEN_W-1:0]    blen;
	logic                bytes_left;
	logic                go;
	logic [7:0]          wr_byte;
	logic [BKT_W-1:0]    head_wa;
	logic                cap_wr;

	khte_bmod #(
		.BUCKETS (BUCKETS)
	) u_bmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mod_start),
		.val    (hash_q),
		.done   (mod_done),
		.bkt    (bkt)
	);

	always_comb begin
		blen       = cmd.len_meta ? len_rd : rlen_q;
		bytes_left = (bi_q < blen);
		go         = cmd.byte_go && bytes_left;
		wr_byte    = cmd.wr_from_key ? key_rd : cap_rd;
		head_wa    = cmd.head_clr ? clr_q : bkt;
		cap_wr     = cmd.take_item && has_byte && (rlen_q < LEN_MAX);
	end

	// running hash is shared with the rebuild pass over stored keys
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= khte_pkg::FNV_BASIS;
			rlen_q <= '0;
		end else if (cmd.out_load) begin
			hash_q <= khte_pkg::FNV_BASIS;
			rlen_q <= '0;
		end else if (cmd.take_item && has_byte) begin
			hash_q <= khte_pkg::hash_step(hash_q, key_byte);
			if (rlen_q <= LEN_MAX) begin
				rlen_q <= rlen_q + LEN_W'(1);
			end
		end else if (cmd.hash_init) begin
			hash_q <= khte_pkg::FNV_BASIS;
		end else if (vld_s1 && cmd.byte_hash) begin
			hash_q <= khte_pkg::hash_step(hash_q, key_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			cmd_q  <= command;
			code_q <= code_in;
			ext_q  <= extension_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cur_head) begin
			cur_q <= head_rd;
		end else if (cmd.cur_next) begin
			cur_q <= next_rd;
		end else if (cmd.add_init) begin
			cur_q <= cnt_q;
		end else if (cmd.cur_zero) begin
			cur_q <= '0;
		end else if (cmd.cur_inc) begin
			cur_q <= cur_q + CNT_W'(1);
		end
		if (cmd.add_init) begin
			dst_q <= cnt_q;
		end else if (cmd.dst_zero) begin
			dst_q <= '0;
		end else if (cmd.dst_inc) begin
			dst_q <= dst_q + CNT_W'(1);
		end
		if (cmd.bi_clr) begin
			bi_q <= '0;
		end else if (go) begin
			bi_q <= bi_q + LEN_W'(1);
		end
		bi_s1 <= bi_q;
		if (cmd.bi_clr) begin
			mis_q <= 1'b0;
		end else if (vld_s1 && cmd.byte_cmp &&
				khte_pkg::fold_case(key_rd) != khte_pkg::fold_case(cap_rd)) begin
			mis_q <= 1'b1;
		end
		if (cmd.res_set) begin
			res_st_q   <= cmd.res_status;
			res_code_q <= cmd.res_hit ? code_rd : 16'd0;
		end
		if (cmd.out_load) begin
			out_st_q   <= res_st_q;
			out_code_q <= res_code_q;
			out_ver_q  <= ver_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ver_q       <= '0;
			vld_s1      <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_from_dst) begin
				cnt_q <= dst_q;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.ver_inc) begin
				ver_q <= ver_q + 32'd1;
			end
			vld_s1 <= go;
			if (cmd.head_clr) begin
				clr_q <= (clr_q == BKT_LAST) ? '0 : clr_q + BKT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// key rows are a power of two wide so the address is a plain concatenation
	always_ff @(posedge clk) begin
		if (vld_s1 && cmd.byte_wr) begin
			key_mem[{dst_q[ENT_W-1:0], bi_s1[KB_W-1:0]}] <= wr_byte;
		end
		key_rd <= key_mem[{cur_q[ENT_W-1:0], bi_q[KB_W-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (cap_wr) begin
			cap_mem[rlen_q[KB_W-1:0]] <= key_byte;
		end
		cap_rd <= cap_mem[bi_q[KB_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.meta_wr_new) begin
			len_mem[dst_q[ENT_W-1:0]]  <= rlen_q;
			code_mem[dst_q[ENT_W-1:0]] <= code_q;
			ext_mem[dst_q[ENT_W-1:0]]  <= ext_q;
		end else if (cmd.meta_wr_copy) begin
			len_mem[dst_q[ENT_W-1:0]]  <= len_rd;
			code_mem[dst_q[ENT_W-1:0]] <= code_rd;
			ext_mem[dst_q[ENT_W-1:0]]  <= ext_rd;
		end
		len_rd  <= len_mem[cur_q[ENT_W-1:0]];
		code_rd <= code_mem[cur_q[ENT_W-1:0]];
		ext_rd  <= ext_mem[cur_q[ENT_W-1:0]];
	end

	// linking puts the entry at the chain head of the current bucket
	always_ff @(posedge clk) begin
		if (cmd.link) begin
			next_mem[cur_q[ENT_W-1:0]] <= head_rd;
		end
		next_rd <= next_mem[cur_q[ENT_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.head_clr || cmd.link) begin
			head_mem[head_wa] <= cmd.head_clr ? NO_ENTRY : cur_q;
		end
		head_rd <= head_mem[bkt];
	end

	always_comb begin
		sts.cmd        = cmd_q;
		sts.too_long   = (rlen_q > LEN_MAX);
		sts.mod_done   = mod_done;
		sts.walk_end   = (cur_q >= cnt_q);
		sts.len_eq     = (len_rd == rlen_q);
		sts.mismatch   = mis_q;
		sts.byte_busy  = bytes_left || vld_s1;
		sts.ext_eq     = (ext_rd == ext_q);
		sts.cur_eq_dst = (cur_q == dst_q);
		sts.cur_end    = (cur_q == cnt_q);
		sts.dst_end    = (dst_q == cnt_q);
		sts.full       = (cnt_q >= NO_ENTRY);
		sts.clr_last   = (clr_q == BKT_LAST);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_st_q;
	assign code_out    = out_code_q;
	assign version_out = out_ver_q;

endmodule

// ===== hdl/khte_ctrl.sv =====
// khte_ctrl: command sequencer for lookup, add, remove and chain rebuild
// depends on khte_pkg; drives khte_dpath through dp_cmd_t

module khte_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              last_byte,
	input  khte_pkg::dp_sts_t sts,
	output logic              in_stall,
	output khte_pkg::dp_cmd_t cmd
);

	localparam logic [4:0] S_CLR0  = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DEC   = 5'd2;
	localparam logic [4:0] S_BKT   = 5'd3;
	localparam logic [4:0] S_HEAD  = 5'd4;
	localparam logic [4:0] S_WALK  = 5'd5;
	localparam logic [4:0] S_WMETA = 5'd6;
	localparam logic [4:0] S_WCMP  = 5'd7;
	localparam logic [4:0] S_ACOPY = 5'd8;
	localparam logic [4:0] S_ALINK = 5'd9;
	localparam logic [4:0] S_RMETA = 5'd10;
	localparam logic [4:0] S_RCHK  = 5'd11;
	localparam logic [4:0] S_RCOPY = 5'd12;
	localparam logic [4:0] S_REND  = 5'd13;
	localparam logic [4:0] S_RCLR  = 5'd14;
	localparam logic [4:0] S_RB    = 5'd15;
	localparam logic [4:0] S_RBH   = 5'd16;
	localparam logic [4:0] S_RBB   = 5'd17;
	localparam logic [4:0] S_RBL   = 5'd18;
	localparam logic [4:0] S_DONE  = 5'd19;

	logic [4:0] state_q;
	logic [4:0] state_nxt;
	logic       is_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR0;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign is_add   = (sts.cmd == khte_pkg::CMD_ADD);
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_CLR0: begin
				cmd.head_clr = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_item = 1'b1;
					if (last_byte) begin
						state_nxt = S_DEC;
					end
				end
			end
			S_DEC: begin
				if (sts.cmd == khte_pkg::CMD_REMOVE) begin
					cmd.cur_zero = 1'b1;
					cmd.dst_zero = 1'b1;
					state_nxt    = S_RMETA;
				end else if (sts.too_long) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = is_add ? khte_pkg::ST_LONG : khte_pkg::ST_MISS;
					state_nxt      = S_DONE;
				end else begin
					cmd.mod_start = 1'b1;
					state_nxt     = S_BKT;
				end
			end
			S_BKT: begin
				if (sts.mod_done) begin
					state_nxt = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.cur_head = 1'b1;
				state_nxt    = S_WALK;
			end
			S_WALK: begin
				if (!sts.walk_end) begin
					state_nxt = S_WMETA;
				end else if (!is_add) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = khte_pkg::ST_MISS;
					state_nxt      = S_DONE;
				end else if (sts.full) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = khte_pkg::ST_FULL;
					state_nxt      = S_DONE;
				end else begin
					cmd.add_init = 1'b1;
					cmd.bi_clr   = 1'b1;
					state_nxt    = S_ACOPY;
				end
			end
			S_WMETA: begin
				if (sts.len_eq) begin
					cmd.bi_clr = 1'b1;
					state_nxt  = S_WCMP;
				end else begin
					cmd.cur_next = 1'b1;
					state_nxt    = S_WALK;
				end
			end
			S_WCMP: begin
				cmd.byte_go  = 1'b1;
				cmd.byte_cmp = 1'b1;
				if (!sts.byte_busy) begin
					if (!sts.mismatch) begin
						cmd.res_set    = 1'b1;
						cmd.res_hit    = !is_add;
						cmd.res_status = is_add ? khte_pkg::ST_DUP : khte_pkg::ST_OK;
						state_nxt      = S_DONE;
					end else begin
						cmd.cur_next = 1'b1;
						state_nxt    = S_WALK;
					end
				end
			end
			S_ACOPY: begin
				cmd.byte_go = 1'b1;
				cmd.byte_wr = 1'b1;
				if (!sts.byte_busy) begin
					state_nxt = S_ALINK;
				end
			end
			S_ALINK: begin
				cmd.link        = 1'b1;
				cmd.meta_wr_new = 1'b1;
				cmd.cnt_inc     = 1'b1;
				cmd.ver_inc     = 1'b1;
				cmd.res_set     = 1'b1;
				cmd.res_status  = khte_pkg::ST_OK;
				state_nxt       = S_DONE;
			end
			S_RMETA: begin
				state_nxt = sts.cur_end ? S_REND : S_RCHK;
			end
			S_RCHK: begin
				if (sts.ext_eq) begin
					cmd.cur_inc = 1'b1;
					state_nxt   = S_RMETA;
				end else if (sts.cur_eq_dst) begin
					cmd.cur_inc = 1'b1;
					cmd.dst_inc = 1'b1;
					state_nxt   = S_RMETA;
				end else begin
					cmd.meta_wr_copy = 1'b1;
					cmd.bi_clr       = 1'b1;
					state_nxt        = S_RCOPY;
				end
			end
			S_RCOPY: begin
				cmd.byte_go     = 1'b1;
				cmd.len_meta    = 1'b1;
				cmd.byte_wr     = 1'b1;
				cmd.wr_from_key = 1'b1;
				if (!sts.byte_busy) begin
					cmd.cur_inc = 1'b1;
					cmd.dst_inc = 1'b1;
					state_nxt   = S_RMETA;
				end
			end
			S_REND: begin
				if (sts.dst_end) begin
					cmd.res_set    = 1'b1;
					cmd.res_status = khte_pkg::ST_NONE;
					state_nxt      = S_DONE;
				end else begin
					cmd.cnt_from_dst = 1'b1;
					state_nxt        = S_RCLR;
				end
			end
			S_RCLR: begin
				cmd.head_clr = 1'b1;
				if (sts.clr_last) begin
					cmd.cur_zero = 1'b1;
					state_nxt    = S_RB;
				end
			end
			S_RB: begin
				if (sts.cur_end) begin
					cmd.ver_inc    = 1'b1;
					cmd.res_set    = 1'b1;
					cmd.res_status = khte_pkg::ST_OK;
					state_nxt      = S_DONE;
				end else begin
					cmd.hash_init = 1'b1;
					cmd.bi_clr    = 1'b1;
					state_nxt     = S_RBH;
				end
			end
			S_RBH: begin
				cmd.byte_go   = 1'b1;
				cmd.len_meta  = 1'b1;
				cmd.byte_hash = 1'b1;
				if (!sts.byte_busy) begin
					cmd.mod_start = 1'b1;
					state_nxt     = S_RBB;
				end
			end
			S_RBB: begin
				if (sts.mod_done) begin
					state_nxt = S_RBL;
				end
			end
			S_RBL: begin
				cmd.link    = 1'b1;
				cmd.cur_inc = 1'b1;
				state_nxt   = S_RB;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/keyword_hash_table_engine_top.sv =====
// Keyword hash table engine. Key bytes arrive one word per cycle while in_stall is low and are
// folded into a case-insensitive FNV-1a hash; a word with last_byte set runs lookup, add or
// remove and yields one result word. The bucket index is masked from the hash when BUCKETS
// is a power of two and reduced one hash byte at a time otherwise. A lookup or add then walks
// the bucket's chain and compares the key byte by byte with each entry whose length matches;
// an add that finds no match copies the key into a new entry. Remove scans every entry, moves
// each survivor that follows a removed entry down and, when any entry was removed, clears the
// bucket heads and rehashes each remaining entry. All of this is paced by the entry and key
// memories walked by the sequencer. After reset the bucket heads are cleared before the
// first word is taken.
// depends on khte_pkg, khte_ctrl, khte_dpath

module keyword_hash_table_engine_top #(
	parameter int MAX_ENTRIES = 64,
	parameter int BUCKETS     = 128,
	parameter int MAX_KEY_LEN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  key_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	input  logic [15:0] code_in,
	input  logic [7:0]  extension_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] code_out,
	output logic [31:0] version_out
);

	khte_pkg::dp_cmd_t cmd;
	khte_pkg::dp_sts_t sts;

	khte_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.BUCKETS     (BUCKETS),
		.MAX_KEY_LEN (MAX_KEY_LEN)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.command      (command),
		.key_byte     (key_byte),
		.has_byte     (has_byte),
		.code_in      (code_in),
		.extension_in (extension_in),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.status       (status),
		.code_out     (code_out),
		.version_out  (version_out)
	);

	khte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_byte (last_byte),
		.sts       (sts),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	// a closing word always starts a command, so the input stalls right after it
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte |=> in_stall)
		else $error("input not stalled after closing word");

	// a result is only loaded into a free output register
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over a waiting word");

	// the walk pointer has one source per cycle
	a_cur_src: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.cur_head, cmd.cur_next, cmd.cur_inc, cmd.cur_zero, cmd.add_init}))
		else $error("conflicting entry pointer updates");

	// a loaded result carries a defined status code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_set |-> cmd.res_status <= khte_pkg::ST_NONE)
		else $error("undefined status code");

endmodule
